>>> hdl/dnc_pkg.sv
// Shared constants and the month-start table for the day number to calendar date block.
// Used by day_number_to_calendar_date; depends on nothing else.
package dnc_pkg;

  localparam int unsigned NUM_STAGES = 10;

  // Day number 4 is 1801-01-01 and day 0 of the count is 1601-01-01, so the shift is
  // 73048 - 4.
  localparam logic [22:0] EPOCH_SHIFT = 23'd73044;

  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [8:0]  DAYS_1Y   = 9'd365;

  // Reciprocal estimates: floor(x * R >> S) never exceeds x / D and falls short by at most one.
  localparam logic [5:0] RECIP_400Y = 6'd57;   // floor(2^23 / 146097)
  localparam logic [5:0] RECIP_4Y   = 6'd44;   // floor(2^16 / 1461)

  localparam logic [13:0] YEAR_BASE = 14'd1601;
  localparam logic [13:0] YEAR_LOW  = 14'd1971;
  localparam logic [13:0] YEAR_HIGH = 14'd9999;

  localparam logic [4:0] LAST_4Y_OF_CENTURY = 5'd24;
  localparam logic [1:0] LAST_CENTURY       = 2'd3;
  localparam logic [1:0] LAST_YEAR_OF_4Y    = 2'd3;

  // First zero-based day of month idx (0 is January); leap years shift March onward by one.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    logic [8:0] adj;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    adj = (leap && (idx >= 4'd2)) ? 9'd1 : 9'd0;
    return base + adj;
  endfunction

endpackage

>>> hdl/day_number_to_calendar_date.sv
// Day number to Gregorian date converter, a ten-stage pipeline with valid/ready words.
// Depends on dnc_pkg for constants and the month-start table.
//
// A user of this block hands in one day number per word and gets back one date word for
// each, in order. Day number 4 is Thursday 1801-01-01; numbers 0 to 3 are the last four
// days of 1800. The result carries the year, month, day of month, weekday (0 is Sunday),
// the zero-based day of the year and date_ok, which is set only for years 1971 to 9999.
// Every 22-bit input is legal. The converter is a ten-stage pipeline: a new word can enter
// in every cycle while results are taken, so the sustained rate is one word per cycle.
// The stages split the day count into 400-year, 100-year, 4-year and single-year cycles;
// the two constant divisions use a reciprocal estimate followed by a one-step correction,
// each in a stage of its own, and the final stage looks the month up in the month-start
// table. The whole pipeline holds when the result at the output is not taken, so
// in_ready_o follows out_ready_i whenever the output register is full, and no word is
// dropped or repeated.
module day_number_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [21:0] day_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] cal_year_o,
  output logic [3:0]  cal_month_o,
  output logic [4:0]  cal_day_o,
  output logic [2:0]  week_day_o,
  output logic [8:0]  year_day_o,
  output logic        date_ok_o
);
  import dnc_pkg::*;

  // One valid bit per stage; bit 0 is stage 1.
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic                  adv;

  // Weekday travels alongside the date through every stage.
  logic [2:0] wday_q [NUM_STAGES];

  // Stage 1: day count from 1601-01-01 and the weekday.
  logic [22:0] s1_d_q;
  logic [5:0]  wd_sum;
  logic [3:0]  wd_fold1;
  logic [3:0]  wd_fold2;
  logic [2:0]  wd_mod;

  // Stage 2: estimate of the 400-year count.
  logic [22:0] s2_d_q;
  logic [4:0]  s2_q_q;
  logic [27:0] s2_prod;

  // Stage 3: remainder of the estimate, may still hold one full cycle.
  logic [18:0] s3_r_q;
  logic [4:0]  s3_q_q;
  logic [22:0] s3_prod;
  logic [22:0] s3_diff;

  // Stage 4: corrected 400-year count and remainder.
  logic [17:0] s4_r_q;
  logic [4:0]  s4_n400_q;

  // Stage 5: century count, clamped so the last day of a 400-year cycle stays in century 3.
  logic [15:0] s5_r_q;
  logic [4:0]  s5_n400_q;
  logic [1:0]  s5_n100_q;
  logic [1:0]  n100_c;
  logic [17:0] r100_c;

  // Stage 6: estimate of the 4-year count.
  logic [15:0] s6_r_q;
  logic [4:0]  s6_q_q;
  logic [4:0]  s6_n400_q;
  logic [1:0]  s6_n100_q;
  logic [20:0] s6_prod;

  // Stage 7: remainder of the 4-year estimate.
  logic [11:0] s7_r_q;
  logic [4:0]  s7_q_q;
  logic [4:0]  s7_n400_q;
  logic [1:0]  s7_n100_q;
  logic [15:0] s7_prod;
  logic [15:0] s7_diff;

  // Stage 8: corrected 4-year count and remainder.
  logic [10:0] s8_r_q;
  logic [4:0]  s8_n4_q;
  logic [4:0]  s8_n400_q;
  logic [1:0]  s8_n100_q;

  // Stage 9: single years, year number and leap flag.
  logic [8:0]  s9_r_q;
  logic [13:0] s9_year_q;
  logic        s9_leap_q;
  logic        s9_ok_q;
  logic [1:0]  n1_c;
  logic [10:0] r1_c;
  logic [13:0] year_c;

  // Stage 10: month lookup, the output register.
  logic [13:0] s10_year_q;
  logic [3:0]  s10_month_q;
  logic [4:0]  s10_day_q;
  logic [8:0]  s10_yday_q;
  logic        s10_ok_q;
  logic [3:0]  m_c;
  logic [8:0]  day_c;

  // The pipeline moves as a whole unless a finished word waits at the output.
  assign adv        = !valid_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = adv;
  assign valid_d    = {valid_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= valid_d;
    end
  end

  // Weekday: 8 is 1 mod 7, so octal digits are summed and folded twice.
  always_comb begin
    wd_sum = 6'(day_number_i[2:0])   + 6'(day_number_i[5:3])   + 6'(day_number_i[8:6])
           + 6'(day_number_i[11:9])  + 6'(day_number_i[14:12]) + 6'(day_number_i[17:15])
           + 6'(day_number_i[20:18]) + 6'(day_number_i[21]);
    wd_fold1 = 4'(wd_sum[5:3]) + 4'(wd_sum[2:0]);
    wd_fold2 = 4'(wd_fold1[2:0]) + 4'(wd_fold1[3]);
    wd_mod   = (wd_fold2 >= 4'd7) ? 3'(wd_fold2 - 4'd7) : wd_fold2[2:0];
  end

  always_comb begin
    s2_prod = 28'(s1_d_q) * 28'(RECIP_400Y);
    s3_prod = 23'(s2_q_q) * 23'(DAYS_400Y);
    s3_diff = s2_d_q - s3_prod;
  end

  always_comb begin
    if (s4_r_q >= 18'(DAYS_100Y) * 18'd3) begin
      n100_c = 2'd3;
    end else if (s4_r_q >= 18'(DAYS_100Y) * 18'd2) begin
      n100_c = 2'd2;
    end else if (s4_r_q >= 18'(DAYS_100Y)) begin
      n100_c = 2'd1;
    end else begin
      n100_c = 2'd0;
    end
    r100_c = s4_r_q - 18'(n100_c) * 18'(DAYS_100Y);
  end

  always_comb begin
    s6_prod = 21'(s5_r_q) * 21'(RECIP_4Y);
    s7_prod = 16'(s6_q_q) * 16'(DAYS_4Y);
    s7_diff = s6_r_q - s7_prod;
  end

  // The fourth year of a 4-year cycle is the leap year; a century's last one only in
  // the last century of a 400-year cycle.
  always_comb begin
    if (s8_r_q >= 11'(DAYS_1Y) * 11'd3) begin
      n1_c = 2'd3;
    end else if (s8_r_q >= 11'(DAYS_1Y) * 11'd2) begin
      n1_c = 2'd2;
    end else if (s8_r_q >= 11'(DAYS_1Y)) begin
      n1_c = 2'd1;
    end else begin
      n1_c = 2'd0;
    end
    r1_c   = s8_r_q - 11'(n1_c) * 11'(DAYS_1Y);
    year_c = YEAR_BASE + 14'(s8_n400_q) * 14'd400 + 14'(s8_n100_q) * 14'd100
           + 14'(s8_n4_q) * 14'd4 + 14'(n1_c);
  end

  // The last month whose start does not lie past the day of year.
  always_comb begin
    m_c = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s9_r_q >= month_start(s9_leap_q, 4'(k))) begin
        m_c = 4'(k);
      end
    end
    day_c = s9_r_q - month_start(s9_leap_q, m_c) + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_d_q    <= 23'(day_number_i) + EPOCH_SHIFT;
      wday_q[0] <= wd_mod;
      for (int i = 1; i < NUM_STAGES; i++) begin
        wday_q[i] <= wday_q[i-1];
      end

      s2_d_q <= s1_d_q;
      s2_q_q <= s2_prod[27:23];

      s3_r_q <= s3_diff[18:0];
      s3_q_q <= s2_q_q;

      if (s3_r_q >= 19'(DAYS_400Y)) begin
        s4_r_q    <= 18'(s3_r_q - 19'(DAYS_400Y));
        s4_n400_q <= s3_q_q + 5'd1;
      end else begin
        s4_r_q    <= s3_r_q[17:0];
        s4_n400_q <= s3_q_q;
      end

      s5_r_q    <= r100_c[15:0];
      s5_n400_q <= s4_n400_q;
      s5_n100_q <= n100_c;

      s6_r_q    <= s5_r_q;
      s6_q_q    <= s6_prod[20:16];
      s6_n400_q <= s5_n400_q;
      s6_n100_q <= s5_n100_q;

      s7_r_q    <= s7_diff[11:0];
      s7_q_q    <= s6_q_q;
      s7_n400_q <= s6_n400_q;
      s7_n100_q <= s6_n100_q;

      if (s7_r_q >= 12'(DAYS_4Y)) begin
        s8_r_q  <= 11'(s7_r_q - 12'(DAYS_4Y));
        s8_n4_q <= s7_q_q + 5'd1;
      end else begin
        s8_r_q  <= s7_r_q[10:0];
        s8_n4_q <= s7_q_q;
      end
      s8_n400_q <= s7_n400_q;
      s8_n100_q <= s7_n100_q;

      s9_r_q    <= r1_c[8:0];
      s9_year_q <= year_c;
      s9_leap_q <= (n1_c == LAST_YEAR_OF_4Y) &&
                   ((s8_n4_q != LAST_4Y_OF_CENTURY) || (s8_n100_q == LAST_CENTURY));
      s9_ok_q   <= (year_c >= YEAR_LOW) && (year_c <= YEAR_HIGH);

      s10_year_q  <= s9_year_q;
      s10_month_q <= m_c + 4'd1;
      s10_day_q   <= day_c[4:0];
      s10_yday_q  <= s9_r_q;
      s10_ok_q    <= s9_ok_q;
    end
  end

  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign cal_year_o  = s10_year_q;
  assign cal_month_o = s10_month_q;
  assign cal_day_o   = s10_day_q;
  assign week_day_o  = wday_q[NUM_STAGES-1];
  assign year_day_o  = s10_yday_q;
  assign date_ok_o   = s10_ok_q;

  // The corrected 400-year remainder is always below one full cycle.
  a_rem_400y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> (s4_r_q < DAYS_400Y))
    else $error("400-year remainder out of range");

  // The corrected 4-year count and remainder stay inside one century.
  a_rem_4y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[7] |-> ((s8_r_q < DAYS_4Y) && (s8_n4_q <= LAST_4Y_OF_CENTURY)))
    else $error("4-year split out of range");

  // Month from the lookup lies in 1 to 12, the day of month is at least 1 and the weekday at most 6.
  a_month_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((cal_month_o >= 4'd1) && (cal_month_o <= 4'd12) &&
                     (cal_day_o >= 5'd1) && (week_day_o <= 3'd6)))
    else $error("month, day or weekday out of range");

  // Day 365 of a year only exists as 31 December of a leap year.
  a_last_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (year_day_o == 9'd365)) |->
      ((cal_month_o == 4'd12) && (cal_day_o == 5'd31)))
    else $error("day of year 365 not on 31 December");

endmodule
